### rtl/core/sbda_pkg.sv
// ----------------------------------------------------------------------------
// sbda_pkg
// Shared types and constants for the signed binary to decimal text converter.
// ----------------------------------------------------------------------------
package sbda_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned DIGITS  = 19;
  localparam int unsigned BCD_W   = DIGITS * 4;
  localparam int unsigned CHAR_W  = 6;
  localparam int unsigned STEP_W  = $clog2(VALUE_W);
  localparam int unsigned REM_W   = $clog2(DIGITS + 1);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

  typedef struct packed {
    logic             done;
    logic [BCD_W-1:0] bcd;
  } conv_res_t;

endpackage

### rtl/core/sbda_conv.sv
// ----------------------------------------------------------------------------
// sbda_conv
// Shift-and-add-3 binary to BCD converter, one magnitude bit per cycle.
// ----------------------------------------------------------------------------
module sbda_conv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [sbda_pkg::VALUE_W-1:0]  mag,
  output sbda_pkg::conv_res_t           res
);
  import sbda_pkg::*;

  logic               run_r,  run_nxt;
  logic               done_r, done_nxt;
  logic [STEP_W-1:0]  cnt_r,  cnt_nxt;
  logic [VALUE_W-1:0] sh_r,   sh_nxt;
  logic [BCD_W-1:0]   bcd_r,  bcd_nxt;
  logic [BCD_W-1:0]   adj;

  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      adj[d*4 +: 4] = (bcd_r[d*4 +: 4] >= 4'd5) ? (bcd_r[d*4 +: 4] + 4'd3)
                                                : bcd_r[d*4 +: 4];
    end
  end

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    bcd_nxt  = bcd_r;
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      sh_nxt  = mag;
      bcd_nxt = '0;
    end else if (run_r) begin
      bcd_nxt = {adj[BCD_W-2:0], sh_r[VALUE_W-1]};
      sh_nxt  = {sh_r[VALUE_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == STEP_W'(VALUE_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
  end

  assign res.done = done_r;
  assign res.bcd  = bcd_r;

endmodule

### rtl/core/signed_binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Converts a signed 64-bit word to decimal ASCII text, most significant first.
// One word at a time: 64 bit-serial BCD steps, then a scan over all 19 BCD
// digits; busy is high until the last char, and start is ignored while busy.
// Results are strobed on out_valid for one cycle each; the receiver cannot stall.
// Reset (rst_n low, synchronous) returns to idle and drops any word in flight.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [sbda_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  output logic [sbda_pkg::CHAR_W-1:0]         out_character,
  output logic                                out_last_char
);
  import sbda_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic              neg_r,   neg_nxt;
  logic              start_r, start_nxt;
  logic [REM_W-1:0]  rem_r,   rem_nxt;
  logic [BCD_W-1:0]  dig_r,   dig_nxt;
  logic              val_r,   val_nxt;
  logic [CHAR_W-1:0] chr_r,   chr_nxt;
  logic              last_r,  last_nxt;

  logic [VALUE_W-1:0] uval;
  logic [VALUE_W-1:0] mag;
  logic               go;
  logic [3:0]         top;
  conv_res_t          cres;

  assign uval = VALUE_W'(unsigned'(in_value));
  assign mag  = uval[VALUE_W-1] ? (~uval + VALUE_W'(1)) : uval;
  assign go   = start && !busy;
  assign top  = dig_r[BCD_W-1 -: 4];

  sbda_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .mag   (mag),
    .res   (cres)
  );

  always_comb begin
    state_nxt = state_r;
    neg_nxt   = neg_r;
    start_nxt = start_r;
    rem_nxt   = rem_r;
    dig_nxt   = dig_r;
    val_nxt   = 1'b0;
    chr_nxt   = chr_r;
    last_nxt  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (go) begin
          neg_nxt   = uval[VALUE_W-1];
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (cres.done) begin
          dig_nxt   = cres.bcd;
          rem_nxt   = REM_W'(DIGITS);
          start_nxt = 1'b0;
          val_nxt   = neg_r;
          chr_nxt   = CHAR_MINUS;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        dig_nxt = {dig_r[BCD_W-5:0], 4'd0};
        rem_nxt = rem_r - 1'b1;
        if (start_r || top != 4'd0 || rem_r == REM_W'(1)) begin
          start_nxt = 1'b1;
          val_nxt   = 1'b1;
          chr_nxt   = CHAR_ZERO + CHAR_W'(top);
          last_nxt  = (rem_r == REM_W'(1));
        end
        if (rem_r == REM_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      val_r   <= 1'b0;
      last_r  <= 1'b0;
      start_r <= 1'b0;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      val_r   <= val_nxt;
      last_r  <= last_nxt;
      start_r <= start_nxt;
      rem_r   <= rem_nxt;
    end
    neg_r <= neg_nxt;
    dig_r <= dig_nxt;
    chr_r <= chr_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = val_r;
  assign out_character = chr_r;
  assign out_last_char = last_r;

endmodule

### rtl/core/sbda_chk.sv
// ----------------------------------------------------------------------------
// sbda_chk
// Port-level checks for the decimal text converter, bound to the top level.
// ----------------------------------------------------------------------------
module sbda_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                out_valid,
  input logic [sbda_pkg::CHAR_W-1:0]         out_character,
  input logic                                out_last_char
);
  import sbda_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accepted word");

  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_valid)
    else $error("character strobed straight after accepted word");

  a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character == CHAR_MINUS) ||
                  (out_character >= CHAR_ZERO && out_character <= CHAR_ZERO + 6'd9))
    else $error("character code out of range");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_character == CHAR_MINUS |-> !out_last_char)
    else $error("minus sign marked last");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_char |-> !busy)
    else $error("still busy on last character");

endmodule

bind signed_binary_to_decimal_ascii sbda_chk u_sbda_chk (.*);
